[rtl/core/stfs_pkg.sv]
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared widths, codes and types of the slot table with free stack.
// ----------------------------------------------------------------------------
package stfs_pkg;

    localparam int STFS_SLOTS_DEFAULT = 32;

    localparam int ACTION_W  = 2;
    localparam int SLOT_ID_W = 5;
    localparam int OFFSET_W  = 32;
    localparam int COLOR_W   = 4;
    localparam int STATUS_W  = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEAD = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

endpackage

[rtl/core/slot_table_free_stack_top.sv]
// ----------------------------------------------------------------------------
// slot_table_free_stack_top
// Slot table of highlight ranges with LIFO reuse of freed slot ids.
// ----------------------------------------------------------------------------
// Each transaction (add, delete or look up) gives one result. It passes
// through the input register, where the entry RAM read issued at acceptance
// returns, and then the result register, which loads as it leaves the input
// register; a stalled output holds it in the input register. One transaction
// is accepted per cycle while the output is not stalled; the live marks, the
// high-water mark and the free stack (top register plus a RAM that prefetches
// the entry below the top) update as a transaction leaves the input register.
// A new transaction is taken into an empty input register while a finished
// result still waits on a stalled output. No clearing pass after reset: only
// valid flags, live marks, counters and the no-color register are cleared.
// ----------------------------------------------------------------------------
module slot_table_free_stack_top
    import stfs_pkg::*;
#(
    parameter int SLOTS = STFS_SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [COLOR_W-1:0]   cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ACTION_W-1:0]  action,
    input  logic [SLOT_ID_W-1:0] slot_id,
    input  logic [OFFSET_W-1:0]  start_offset,
    input  logic [OFFSET_W-1:0]  end_offset,
    input  logic [COLOR_W-1:0]   color_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SLOT_ID_W-1:0] result_slot,
    output logic [STATUS_W-1:0]  status,
    output logic [COLOR_W-1:0]   found_color,
    output logic [OFFSET_W-1:0]  found_start,
    output logic [OFFSET_W-1:0]  found_end
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;
    localparam int EW = 2 * OFFSET_W + COLOR_W;

    logic [COLOR_W-1:0]   no_color_reg;

    logic                 s1_valid_reg;
    logic [ACTION_W-1:0]  s1_action_reg;
    logic [SLOT_ID_W-1:0] s1_slot_reg;
    logic [OFFSET_W-1:0]  s1_start_reg;
    logic [OFFSET_W-1:0]  s1_end_reg;
    logic [COLOR_W-1:0]   s1_color_reg;
    logic                 ent_byp_valid_reg;
    logic [EW-1:0]        ent_byp_data_reg;

    logic [SLOTS-1:0]     live_reg;
    logic [CW-1:0]        hw_reg;
    logic [CW-1:0]        hw_next;

    logic                 out_valid_reg;
    logic [SLOT_ID_W-1:0] res_slot_reg;
    status_t              res_status_reg;
    logic [COLOR_W-1:0]   res_color_reg;
    logic [OFFSET_W-1:0]  res_start_reg;
    logic [OFFSET_W-1:0]  res_end_reg;

    logic [SLOT_ID_W-1:0] res_slot_next;
    status_t              res_status_next;
    logic [COLOR_W-1:0]   res_color_next;
    logic [OFFSET_W-1:0]  res_start_next;
    logic [OFFSET_W-1:0]  res_end_next;

    logic                 s1_move;
    logic                 in_fire;
    logic [SW-1:0]        sid_idx;
    logic                 sid_live;
    logic                 add_ok;
    logic                 del_ok;
    logic                 take_free;
    logic [SW-1:0]        alloc_id;

    logic                 ent_wr_en;
    logic [SW-1:0]        ent_rd_addr;
    logic [EW-1:0]        ent_rd_data;
    logic [EW-1:0]        ent_data;

    stack_cmd_t           fs_cmd;
    logic [SW-1:0]        fs_top;
    logic [CW-1:0]        fs_count;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_fire  = in_valid && !in_stall;

    assign sid_idx  = SW'(s1_slot_reg);
    assign sid_live = (32'(s1_slot_reg) < SLOTS) && live_reg[sid_idx];
    assign ent_data = ent_byp_valid_reg ? ent_byp_data_reg : ent_rd_data;

    always_comb
    begin
        add_ok          = 1'b0;
        del_ok          = 1'b0;
        take_free       = 1'b0;
        alloc_id        = fs_top;
        hw_next         = hw_reg;
        res_slot_next   = s1_slot_reg;
        res_status_next = ST_OK;
        res_color_next  = '0;
        res_start_next  = '0;
        res_end_next    = '0;
        case (action_t'(s1_action_reg))
            ACT_ADD:
            begin
                if (fs_count != '0)
                begin
                    add_ok    = 1'b1;
                    take_free = 1'b1;
                end
                else if (hw_reg < CW'(SLOTS))
                begin
                    add_ok   = 1'b1;
                    alloc_id = SW'(hw_reg);
                    hw_next  = hw_reg + CW'(1);
                end
                if (add_ok)
                begin
                    res_slot_next = SLOT_ID_W'(alloc_id);
                end
                else
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_FULL;
                end
            end
            ACT_DELETE:
            begin
                if (sid_live && (fs_count < CW'(SLOTS)))
                begin
                    del_ok = 1'b1;
                end
                else
                begin
                    res_status_next = ST_DEAD;
                end
            end
            default:
            begin
                if (sid_live)
                begin
                    res_color_next = ent_data[COLOR_W-1:0];
                    res_end_next   = ent_data[OFFSET_W+COLOR_W-1:COLOR_W];
                    res_start_next = ent_data[EW-1:OFFSET_W+COLOR_W];
                end
                else
                begin
                    res_status_next = ST_DEAD;
                    res_color_next  = no_color_reg;
                end
            end
        endcase
    end

    assign fs_cmd.push = s1_move && del_ok;
    assign fs_cmd.pop  = s1_move && take_free;

    stfs_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (fs_cmd),
        .push_id (sid_idx),
        .top_id  (fs_top),
        .count   (fs_count)
    );

    assign ent_wr_en   = s1_move && add_ok;
    assign ent_rd_addr = SW'(slot_id);

    stfs_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (alloc_id),
        .wr_data ({s1_start_reg, s1_end_reg, s1_color_reg}),
        .rd_en   (in_fire),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_color_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_reg      <= '0;
            hw_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                no_color_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= in_fire || (s1_valid_reg && !s1_move);
            out_valid_reg <= s1_move || (out_valid_reg && out_stall);
            if (s1_move)
            begin
                hw_reg <= hw_next;
                if (add_ok)
                begin
                    live_reg[alloc_id] <= 1'b1;
                end
                if (del_ok)
                begin
                    live_reg[sid_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg     <= action;
            s1_slot_reg       <= slot_id;
            s1_start_reg      <= start_offset;
            s1_end_reg        <= end_offset;
            s1_color_reg      <= color_code;
            ent_byp_valid_reg <= ent_wr_en && (alloc_id == ent_rd_addr);
            ent_byp_data_reg  <= {s1_start_reg, s1_end_reg, s1_color_reg};
        end
        if (s1_move)
        begin
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            res_color_reg  <= res_color_next;
            res_start_reg  <= res_start_next;
            res_end_reg    <= res_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_slot = res_slot_reg;
    assign status      = res_status_reg;
    assign found_color = res_color_reg;
    assign found_start = res_start_reg;
    assign found_end   = res_end_reg;

    a_slot_accounting: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(live_reg) + 32'(fs_count) == 32'(hw_reg))
        else $error("live slots plus free ids differ from high-water mark");

    a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && (res_status_next == ST_FULL) |-> (fs_count == '0) && (hw_reg == CW'(SLOTS)))
        else $error("full reported while a slot was still available");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fs_cmd.pop |-> (fs_count != '0))
        else $error("free stack popped while empty");

    a_result_follows_move: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("transaction left the input register without a result");

endmodule

[rtl/core/stfs_ram.sv]
// ----------------------------------------------------------------------------
// stfs_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module stfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/stfs_free_stack.sv]
// ----------------------------------------------------------------------------
// stfs_free_stack
// LIFO of freed slot ids: top entry in a register, the rest in a RAM whose
// read port always prefetches the entry just below the top.
// ----------------------------------------------------------------------------
module stfs_free_stack
    import stfs_pkg::*;
#(
    parameter int SLOTS = STFS_SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stack_cmd_t                 cmd,
    input  logic [$clog2(SLOTS)-1:0]   push_id,
    output logic [$clog2(SLOTS)-1:0]   top_id,
    output logic [$clog2(SLOTS):0]     count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] top_reg;
    logic [SW-1:0] top_next;
    logic          byp_valid_reg;
    logic          byp_valid_next;
    logic [SW-1:0] byp_data_reg;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] rd_data;
    logic [SW-1:0] below;

    assign below = byp_valid_reg ? byp_data_reg : rd_data;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = SW'(count_reg - CW'(1));
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = push_id;
            wr_en      = (count_reg != '0);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            top_next   = below;
        end
        rd_addr        = SW'(count_next - CW'(2));
        byp_valid_next = wr_en && (wr_addr == rd_addr);
    end

    stfs_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (1'b1),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

    assign top_id = top_reg;
    assign count  = count_reg;

endmodule
